>>> hdl/pld_pkg.sv
// Package for pooled_linked_deque: sizes, opcode and status codes,
// and the command/status structs between controller and datapath.
// No dependencies.
package pld_pkg;
  localparam int Nodes = 16;
  localparam int DataWidth = 32;
  localparam int IdxW = $clog2(Nodes);
  localparam int PtrW = IdxW + 1;
  localparam int CntW = $clog2(Nodes + 1);
  localparam logic [PtrW-1:0] LinkNull = PtrW'(Nodes);

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0, OP_PREPEND = 3'd1, OP_POP_FRONT = 3'd2, OP_POP_BACK = 3'd3,
    OP_PEEK_FRONT = 3'd4, OP_PEEK_BACK = 3'd5, OP_REMOVE = 3'd6, OP_BAD = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_FULL = 2'd2, ST_INVALID = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic start;   // latch the beat: opcode, data and node index
    logic fetch;   // second step: read data/neighbors, decide and update
    logic finish;  // load the result register and raise result valid
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_full;
  } dp_sts_t;
endpackage

>>> hdl/pld_datapath.sv
// Datapath for pooled_linked_deque: link arrays, in-use bits, pointers,
// count and the result register. Node data lives in pld_ram.
// Depends on pld_pkg and pld_ram.
module pld_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  pld_pkg::dp_cmd_t              cmd,
  output pld_pkg::dp_sts_t              sts,
  input  logic [2:0]                    in_op,
  input  logic [pld_pkg::DataWidth-1:0] in_data,
  input  logic [3:0]                    in_idx,
  output logic                          res_valid,
  input  logic                          res_take,
  output logic [47:0]                   res_data
);
  import pld_pkg::*;

  logic [PtrW-1:0] next_link [Nodes];
  logic [PtrW-1:0] prev_link [Nodes];
  logic [Nodes-1:0] in_use;
  logic [PtrW-1:0] head_ptr, tail_ptr, free_top;
  logic [CntW-1:0] count;

  logic [2:0] op;
  logic [DataWidth-1:0] din;
  logic [3:0] idx;

  // target selection
  logic [PtrW-1:0] tgt;
  logic bad_idx;
  always_comb begin
    bad_idx = 1'b0;
    tgt = LinkNull;
    unique case (op_t'(op))
      OP_APPEND, OP_PREPEND: tgt = free_top;
      OP_POP_FRONT, OP_PEEK_FRONT: tgt = head_ptr;
      OP_POP_BACK, OP_PEEK_BACK: tgt = tail_ptr;
      OP_REMOVE: begin
        if (PtrW'(idx) >= PtrW'(Nodes)) bad_idx = 1'b1;
        else tgt = PtrW'(idx);
      end
      default: bad_idx = 1'b1;
    endcase
  end

  logic tgt_null;
  logic [IdxW-1:0] t;
  assign tgt_null = tgt == LinkNull;
  assign t = tgt[IdxW-1:0];

  status_t st;
  always_comb begin
    st = ST_OK;
    unique case (op_t'(op))
      OP_APPEND, OP_PREPEND: if (tgt_null) st = ST_FULL;
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK:
        if (tgt_null) st = ST_EMPTY;
      OP_REMOVE: if (bad_idx || !in_use[t]) st = ST_INVALID;
      default: st = ST_INVALID;
    endcase
  end

  // node data memory: read at fetch, written on insert
  // after fetch the read address stays on the latched node so the word
  // holds while the result waits for the output register
  logic wr_en;
  logic [DataWidth-1:0] rd_data;
  logic [IdxW-1:0] t_q;
  logic [IdxW-1:0] rd_addr;
  assign wr_en = cmd.fetch && st == ST_OK && (op == OP_APPEND || op == OP_PREPEND);
  assign rd_addr = cmd.fetch ? t : t_q;
  pld_ram #(.Width(DataWidth), .Depth(Nodes)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(t), .wr_data(din),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  status_t st_q;
  logic rd_data_use;
  logic [PtrW-1:0] nx, pv;
  logic [IdxW-1:0] nxi, pvi, hi, tli;
  assign nx = next_link[t];
  assign pv = prev_link[t];
  assign nxi = nx[IdxW-1:0];
  assign pvi = pv[IdxW-1:0];
  assign hi = head_ptr[IdxW-1:0];
  assign tli = tail_ptr[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Nodes; i++) begin
        next_link[i] <= (i + 1 < Nodes) ? PtrW'(i + 1) : LinkNull;
        prev_link[i] <= LinkNull;
      end
      in_use <= '0;
      head_ptr <= LinkNull;
      tail_ptr <= LinkNull;
      free_top <= '0;
      count <= '0;
      res_valid <= 1'b0;
      op <= OP_PEEK_FRONT;
    end else begin
      if (res_take) res_valid <= 1'b0;
      if (cmd.start) begin
        op <= in_op;
        din <= in_data;
        idx <= in_idx;
      end
      if (cmd.fetch) begin
        st_q <= st;
        t_q <= t;
        rd_data_use <= st == ST_OK && (op == OP_POP_FRONT || op == OP_POP_BACK ||
                       op == OP_PEEK_FRONT || op == OP_PEEK_BACK);
        if (st == ST_OK) begin
          if (op == OP_APPEND || op == OP_PREPEND) begin
            free_top <= nx;
            in_use[t] <= 1'b1;
            count <= count + 1'b1;
            if (op == OP_APPEND) begin
              next_link[t] <= LinkNull;
              prev_link[t] <= tail_ptr;
              if (tail_ptr != LinkNull) next_link[tli] <= tgt;
              else head_ptr <= tgt;
              tail_ptr <= tgt;
            end else begin
              prev_link[t] <= LinkNull;
              next_link[t] <= head_ptr;
              if (head_ptr != LinkNull) prev_link[hi] <= tgt;
              else tail_ptr <= tgt;
              head_ptr <= tgt;
            end
          end else if (op != OP_PEEK_FRONT && op != OP_PEEK_BACK) begin
            // unlink then push on the free list
            if (pv != LinkNull) next_link[pvi] <= nx;
            if (nx != LinkNull) prev_link[nxi] <= pv;
            if (head_ptr == tgt) head_ptr <= nx;
            if (tail_ptr == tgt) tail_ptr <= pv;
            in_use[t] <= 1'b0;
            prev_link[t] <= LinkNull;
            next_link[t] <= free_top;
            free_top <= tgt;
            count <= count - 1'b1;
          end
        end
      end
      if (cmd.finish) res_valid <= 1'b1;
    end
  end

  // result: status, data, node, count from the lowest bit up, zero pad on top
  logic [DataWidth-1:0] dsel;
  assign dsel = rd_data_use ? rd_data : '0;
  always_ff @(posedge clk) begin
    if (cmd.finish)
      res_data <= {5'b0, 5'(count), (st_q == ST_OK) ? 4'(t_q) : 4'd0, 32'(dsel), st_q};
  end

  assign sts.out_full = res_valid;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) count <= CntW'(Nodes))
    else $error("count over pool size");
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head_ptr == LinkNull && tail_ptr == LinkNull))
    else $error("empty queue with live ends");
  a_inuse_cnt: assert property (@(posedge clk) disable iff (rst)
    $countones(in_use) == int'(count))
    else $error("in-use bits disagree with count");
`endif
endmodule

>>> hdl/pld_ram.sv
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module pld_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

>>> hdl/pld_ctrl.sv
// Controller for pooled_linked_deque: three-step sequencer per command.
// Depends on pld_pkg.
module pld_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              m_tready,
  input  pld_pkg::dp_sts_t  sts,
  output pld_pkg::dp_cmd_t  cmd
);
  import pld_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_FINISH} state_t;
  state_t state;

  // the result register must be free (or emptying) before finish
  logic out_free;
  assign out_free = !sts.out_full || m_tready;
  assign s_tready = state == S_IDLE;
  assign cmd.start = s_tvalid && s_tready;
  assign cmd.fetch = state == S_FETCH;
  assign cmd.finish = state == S_FINISH && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (s_tvalid) state <= S_FETCH;
        S_FETCH: state <= S_FINISH;
        S_FINISH: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_seq: assert property (@(posedge clk) disable iff (rst) cmd.start |=> cmd.fetch)
    else $error("fetch did not follow accept");
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready)
    else $error("accept while busy");
`endif
endmodule

>>> hdl/pooled_linked_deque.sv
// Top level of pooled_linked_deque: stream ports, controller and datapath.
// Depends on pld_pkg, pld_ctrl, pld_datapath (and pld_ram below it).
//
// A 16-node double-ended queue kept as a doubly linked list over a node
// pool, with a last-in-first-out free list that hands out nodes 0, 1, 2 and
// onward in turn after reset. Each input beat carries one command and gives
// exactly one output beat with status, data, node index and item count. A
// command runs from accept to result in these steps: accept, a step that
// reads the node-data RAM and updates the links, and one that loads the
// output register, kept apart by the registered read port of that RAM. The
// last step stretches while an earlier result still waits on the master side.
// A new beat is accepted while a previous result still waits on that side.
module pooled_linked_deque (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // opcode[2:0], data_in[34:3], node_index[38:35], pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // status[1:0], data_out[33:2], node_out[37:34],
                                // item_count[42:38], pad
);
  import pld_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pld_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tready(m_tready), .sts(sts), .cmd(cmd)
  );

  pld_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_op(s_tdata[2:0]), .in_data(s_tdata[34:3]), .in_idx(s_tdata[38:35]),
    .res_valid(m_tvalid), .res_take(m_tready), .res_data(m_tdata)
  );

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result dropped under stall");
`endif
endmodule

>>> bench/pooled_linked_deque_test.sv
// Testbench for pooled_linked_deque: stream stimulus, a deque predictor and a
// scoreboard class that checks every result beat in order.
// Depends on pld_pkg and the pooled_linked_deque RTL.
`timescale 1ns / 1ps

module pooled_linked_deque_test;
  import pld_pkg::*;

  // lowest field last: count on top, status in the low bits
  typedef struct packed {
    logic [4:0]  count;
    logic [3:0]  node;
    logic [31:0] data;
    logic [1:0]  status;
  } deque_result_t;

  // Predicts the deque and holds the queue of results still due.
  class deque_scoreboard;
    logic [DataWidth-1:0] node_word [Nodes];
    logic [PtrW-1:0] fwd [Nodes];
    logic [PtrW-1:0] back [Nodes];
    bit busy_node [Nodes];
    logic [PtrW-1:0] head, tail, free_top;
    int unsigned depth;
    deque_result_t due_q[$];
    int errors;
    int op_seen [8];
    int status_seen [4];

    function new();
      for (int i = 0; i < Nodes; i++) begin
        node_word[i] = '0;
        fwd[i] = (i + 1 < Nodes) ? PtrW'(i + 1) : LinkNull;
        back[i] = LinkNull;
        busy_node[i] = 0;
      end
      head = LinkNull;
      tail = LinkNull;
      free_top = '0;
      depth = 0;
      errors = 0;
    endfunction

    function void unlink(logic [PtrW-1:0] n);
      logic [PtrW-1:0] nx, pv;
      nx = fwd[n];
      pv = back[n];
      if (pv != LinkNull) fwd[pv] = nx;
      if (nx != LinkNull) back[nx] = pv;
      if (head == n) head = nx;
      if (tail == n) tail = pv;
      busy_node[n] = 0;
      back[n] = LinkNull;
      fwd[n] = free_top;
      free_top = n;
      depth--;
    endfunction

    // Note one accepted command and queue the result it must give.
    function void note_command(op_t op, logic [31:0] din, logic [3:0] idx);
      deque_result_t r;
      logic [PtrW-1:0] n;
      r = '0;
      r.status = ST_OK;
      op_seen[op]++;
      case (op)
        OP_APPEND, OP_PREPEND: begin
          if (free_top == LinkNull) r.status = ST_FULL;
          else begin
            n = free_top;
            free_top = fwd[n];
            node_word[n] = din;
            busy_node[n] = 1;
            if (op == OP_APPEND) begin
              fwd[n] = LinkNull;
              back[n] = tail;
              if (tail != LinkNull) fwd[tail] = n; else head = n;
              tail = n;
            end else begin
              back[n] = LinkNull;
              fwd[n] = head;
              if (head != LinkNull) back[head] = n; else tail = n;
              head = n;
            end
            depth++;
            r.node = n[3:0];
          end
        end
        OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
          n = (op == OP_POP_FRONT || op == OP_PEEK_FRONT) ? head : tail;
          if (n == LinkNull) r.status = ST_EMPTY;
          else begin
            r.data = node_word[n];
            r.node = n[3:0];
            if (op == OP_POP_FRONT || op == OP_POP_BACK) unlink(n);
          end
        end
        OP_REMOVE: begin
          if (!busy_node[idx]) r.status = ST_INVALID;
          else begin
            r.node = idx;
            unlink(PtrW'(idx));
          end
        end
        default: r.status = ST_INVALID;
      endcase
      r.count = 5'(depth);
      status_seen[r.status]++;
      due_q.push_back(r);
    endfunction

    function void check_result(deque_result_t got);
      deque_result_t want;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.data !== want.data) begin
        $display("%0t: data_out expected %h actual %h", $time, want.data, got.data);
        errors++;
      end
      if (got.node !== want.node) begin
        $display("%0t: node_out expected %0d actual %0d", $time, want.node, got.node);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: item_count expected %0d actual %0d", $time, want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  localparam int WatchLimit = 5000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;  // opcode, data_in, node_index, pad
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;  // status, data_out, node_out, item_count, pad

  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;
  deque_scoreboard board;

  pooled_linked_deque DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, checks each accepted result beat.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata[42:0]);
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles where no beat moves on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Drive one command beat; random gap first, hold until accepted.
  // tvalid stays high after the accept; a gap in the next call or the drain drops it.
  task automatic send_command(op_t op, logic [31:0] din, logic [3:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, idx, din, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_command(op, din, idx);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (board.due_q.size() != 0) @(posedge clk);
  endtask

  // Random word with frequent all-zero / all-one extremes.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly busy-node removes so that middle unlinks happen often.
  function automatic logic [3:0] pick_target();
    logic [3:0] k;
    for (int t = 0; t < 8; t++) begin
      k = 4'($urandom_range(Nodes - 1));
      if (board.busy_node[k] && $urandom_range(3) != 0) return k;
    end
    return k;
  endfunction

  task automatic random_phase(int items);
    op_t op;
    int r;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      // bias toward filling when short, toward draining when nearly full
      if (board.depth < 4) op = (r < 60) ? op_t'($urandom_range(1)) : op_t'($urandom_range(7));
      else if (board.depth > 12) op = (r < 60) ? op_t'($urandom_range(3, 2))
                                               : op_t'($urandom_range(7));
      else op = (r < 5) ? OP_BAD : op_t'($urandom_range(6));
      send_command(op, pick_word(), pick_target());
    end
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty pops and peeks, bad opcode and bad remove on empty queue.
    send_command(OP_POP_FRONT, '1, '0);
    send_command(OP_POP_BACK, '0, '0);
    send_command(OP_PEEK_FRONT, '0, '0);
    send_command(OP_PEEK_BACK, '0, '0);
    send_command(OP_REMOVE, '0, 4'd15);
    send_command(OP_BAD, '1, '1);
    // Fill the pool from both ends, then overflow it.
    for (int i = 0; i < Nodes; i++)
      send_command((i % 2) ? OP_PREPEND : OP_APPEND, (i % 3 == 0) ? '1 : $urandom, '0);
    send_command(OP_APPEND, 32'hdead_beef, '0);
    send_command(OP_PREPEND, '0, '0);
    send_command(OP_PEEK_FRONT, '0, '0);
    send_command(OP_PEEK_BACK, '0, '0);
    send_command(OP_REMOVE, '0, 4'd7);   // middle node
    send_command(OP_REMOVE, '0, 4'd7);   // now free: invalid
    // Sender holds off until every result is back.
    drain_results();

    send_idle_pct = 26;
    recv_idle_pct = 76;
    random_phase(210);
    drain_results();
    send_idle_pct = 76;
    recv_idle_pct = 26;
    random_phase(210);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(210);

    drain_results();
    repeat (10) @(posedge clk);
    $display("Covered %0d appends, %0d prepends, %0d pops, %0d peeks, %0d removes, %0d bad ops",
             board.op_seen[OP_APPEND], board.op_seen[OP_PREPEND],
             board.op_seen[OP_POP_FRONT] + board.op_seen[OP_POP_BACK],
             board.op_seen[OP_PEEK_FRONT] + board.op_seen[OP_PEEK_BACK],
             board.op_seen[OP_REMOVE], board.op_seen[OP_BAD]);
    $display("Statuses: %0d ok, %0d empty, %0d full, %0d invalid",
             board.status_seen[ST_OK], board.status_seen[ST_EMPTY],
             board.status_seen[ST_FULL], board.status_seen[ST_INVALID]);
    if (board.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
